FILE: hdl/stable_sort_by_magnitude_macros.svh
// Assertion macros shared by the stable_sort_by_magnitude RTL.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef STABLE_SORT_BY_MAGNITUDE_MACROS_SVH
`define STABLE_SORT_BY_MAGNITUDE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SSBM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define SSBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/ssbm_pkg.sv
// Shared constants, types and the magnitude function of the magnitude sorter.
// No dependencies; used by ssbm_ctrl, ssbm_dp and stable_sort_by_magnitude.
package ssbm_pkg;

  localparam int DEPTH       = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int AW          = $clog2(DEPTH);
  localparam int CW          = $clog2(DEPTH + 1);
  // run bounds reach lo + 2*width, below four times the depth
  localparam int PW          = AW + 2;

  typedef logic [VALUE_WIDTH-1:0] val_t;
  typedef logic [PW-1:0]          idx_t;
  typedef logic [CW-1:0]          cnt_t;

  typedef struct packed {
    logic load;
    logic sort_init;
    logic pass_next;
    logic run_init;
    logic run_next;
    logic cap_a;
    logic cap_b;
    logic merge;
    logic fetch;
    logic emit_init;
    logic emit_rd;
    logic emit_cap;
    logic emit_adv;
    logic clear;
  } ssbm_cmd_t;

  typedef struct packed {
    logic width_done;
    logic set_done;
    logic run_done;
    logic emit_last;
  } ssbm_sts_t;

  // Unsigned absolute value; the most negative pattern maps to itself.
  function automatic val_t magnitude(input val_t v);
    val_t m;
    m = v[VALUE_WIDTH-1] ? (~v + val_t'(1)) : v;
    return m;
  endfunction

endpackage

FILE: hdl/ssbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/ssbm_ctrl.sv
// Sequencer of the magnitude sorter: load, merge passes and emission.
// Depends on ssbm_pkg and stable_sort_by_magnitude_macros.svh.
`include "stable_sort_by_magnitude_macros.svh"

module ssbm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ssbm_pkg::ssbm_sts_t sts,
  output ssbm_pkg::ssbm_cmd_t cmd
);

  import ssbm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_PASS    = 10'b00_0000_0010,
    S_RUN     = 10'b00_0000_0100,
    S_LDA     = 10'b00_0000_1000,
    S_LDB     = 10'b00_0001_0000,
    S_MERGE   = 10'b00_0010_0000,
    S_FETCH   = 10'b00_0100_0000,
    S_EMIT_RD = 10'b00_1000_0000,
    S_EMIT_LD = 10'b01_0000_0000,
    S_EMIT    = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.sort_init = 1'b1;
            state_nxt     = S_PASS;
          end
        end
      end
      S_PASS: begin
        if (sts.width_done) begin
          cmd.emit_init = 1'b1;
          state_nxt     = S_EMIT_RD;
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.set_done) begin
          cmd.pass_next = 1'b1;
          state_nxt     = S_PASS;
        end else begin
          cmd.run_init = 1'b1;
          state_nxt    = S_LDA;
        end
      end
      S_LDA: begin
        cmd.cap_a = 1'b1;
        state_nxt = S_LDB;
      end
      S_LDB: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        if (sts.run_done) begin
          cmd.run_next = 1'b1;
          state_nxt    = S_RUN;
        end else begin
          cmd.merge = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_MERGE;
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.emit_cap = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          if (sts.emit_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.emit_adv = 1'b1;
            state_nxt    = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SSBM_ASSERT_NOW(a_no_load_during_emit, in_ready, !out_valid)
  `SSBM_ASSERT_NEXT(a_last_starts_sort, in_valid && in_ready && in_last, !in_ready)
  `SSBM_ASSERT_NEXT(a_final_item_frees_input, out_valid && out_ready && sts.emit_last, in_ready)

endmodule

FILE: hdl/ssbm_dp.sv
// Datapath of the magnitude sorter: fill counter, run bounds, merge heads,
// two ping-pong RAMs (ssbm_ram), output register. Uses ssbm_pkg and the macros.
`include "stable_sort_by_magnitude_macros.svh"

module ssbm_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ssbm_pkg::ssbm_cmd_t                 cmd,
  output ssbm_pkg::ssbm_sts_t                 sts,
  input  logic [ssbm_pkg::VALUE_WIDTH-1:0]    in_value,
  output logic [ssbm_pkg::VALUE_WIDTH-1:0]    out_value,
  output logic                                out_last,
  output logic                                out_overflowed
);

  import ssbm_pkg::*;

  cnt_t fill_r, fill_nxt;
  logic drop_r, drop_nxt;
  logic par_r, par_nxt;
  logic sel_r, sel_nxt;
  idx_t width_r, width_nxt;
  idx_t lo_r, lo_nxt;
  idx_t i_r, i_nxt;
  idx_t j_r, j_nxt;
  idx_t k_r, k_nxt;
  val_t a_r, a_nxt;
  val_t b_r, b_nxt;
  val_t out_value_r, out_value_nxt;
  logic out_last_r, out_last_nxt;

  idx_t n;
  idx_t lo_w;
  idx_t lo_2w;
  idx_t mid;
  idx_t hi;
  idx_t rd_idx;
  logic full;
  logic left_empty;
  logic right_empty;
  logic take_right;
  val_t merge_data;
  val_t rd_a;
  val_t rd_b;
  val_t rd_data;
  logic we_a;
  logic we_b;
  logic re;
  logic [AW-1:0] waddr_a;
  val_t wdata_a;

  assign n     = idx_t'(fill_r);
  assign full  = (fill_r == cnt_t'(DEPTH));
  assign lo_w  = lo_r + width_r;
  assign lo_2w = lo_r + (width_r << 1);
  assign mid   = (lo_w < n) ? lo_w : n;
  assign hi    = (lo_2w < n) ? lo_2w : n;

  assign left_empty  = (i_r >= mid);
  assign right_empty = (j_r >= hi);
  // right head wins on an empty left run or if strictly smaller: ties keep order
  assign take_right  = left_empty | (~right_empty & (magnitude(b_r) < magnitude(a_r)));
  assign merge_data  = take_right ? b_r : a_r;

  assign sts.width_done = (width_r >= n);
  assign sts.set_done   = (lo_r >= n);
  assign sts.run_done   = left_empty & right_empty;
  assign sts.emit_last  = ((k_r + idx_t'(1)) == n);

  // input goes to RAM A; a pass reads the source side and writes the other
  assign we_a    = (cmd.load & ~full) | (cmd.merge & par_r);
  assign we_b    = cmd.merge & ~par_r;
  assign waddr_a = cmd.load ? fill_r[AW-1:0] : k_r[AW-1:0];
  assign wdata_a = cmd.load ? in_value : merge_data;
  assign re      = cmd.run_init | cmd.cap_a | cmd.merge | cmd.emit_rd;
  assign rd_data = par_r ? rd_b : rd_a;

  always_comb begin
    rd_idx = k_r;
    if (cmd.run_init) begin
      rd_idx = lo_r;
    end else if (cmd.cap_a) begin
      rd_idx = j_r;
    end else if (cmd.merge) begin
      rd_idx = take_right ? (j_r + idx_t'(1)) : (i_r + idx_t'(1));
    end
  end

  ssbm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (wdata_a),
    .re    (re),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_a)
  );

  ssbm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (k_r[AW-1:0]),
    .wdata (merge_data),
    .re    (re),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_b)
  );

  always_comb begin
    fill_nxt      = fill_r;
    drop_nxt      = drop_r;
    par_nxt       = par_r;
    sel_nxt       = sel_r;
    width_nxt     = width_r;
    lo_nxt        = lo_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    if (cmd.load) begin
      if (full) begin
        drop_nxt = 1'b1;
      end else begin
        fill_nxt = fill_r + cnt_t'(1);
      end
    end
    if (cmd.sort_init) begin
      width_nxt = idx_t'(1);
      lo_nxt    = '0;
    end
    if (cmd.pass_next) begin
      width_nxt = width_r << 1;
      lo_nxt    = '0;
      par_nxt   = ~par_r;
    end
    if (cmd.run_init) begin
      i_nxt = lo_r;
      j_nxt = mid;
      k_nxt = lo_r;
    end
    if (cmd.run_next) begin
      lo_nxt = lo_2w;
    end
    if (cmd.cap_a) begin
      a_nxt = rd_data;
    end
    if (cmd.cap_b) begin
      b_nxt = rd_data;
    end
    if (cmd.merge) begin
      k_nxt   = k_r + idx_t'(1);
      sel_nxt = take_right;
      if (take_right) begin
        j_nxt = j_r + idx_t'(1);
      end else begin
        i_nxt = i_r + idx_t'(1);
      end
    end
    if (cmd.fetch) begin
      if (sel_r) begin
        b_nxt = rd_data;
      end else begin
        a_nxt = rd_data;
      end
    end
    if (cmd.emit_init) begin
      k_nxt = '0;
    end
    if (cmd.emit_cap) begin
      out_value_nxt = rd_data;
      out_last_nxt  = sts.emit_last;
    end
    if (cmd.emit_adv) begin
      k_nxt = k_r + idx_t'(1);
    end
    if (cmd.clear) begin
      fill_nxt = '0;
      drop_nxt = 1'b0;
      par_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      drop_r     <= 1'b0;
      par_r      <= 1'b0;
      sel_r      <= 1'b0;
      width_r    <= '0;
      lo_r       <= '0;
      i_r        <= '0;
      j_r        <= '0;
      k_r        <= '0;
      out_last_r <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      drop_r     <= drop_nxt;
      par_r      <= par_nxt;
      sel_r      <= sel_nxt;
      width_r    <= width_nxt;
      lo_r       <= lo_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      k_r        <= k_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_value      = out_value_r;
  assign out_last       = out_last_r;
  assign out_overflowed = drop_r;

  `SSBM_ASSERT_NEXT(a_clear_resets_set, cmd.clear, fill_r == '0 && !drop_r && !par_r)
  `SSBM_ASSERT_NOW(a_fill_in_range, 1'b1, fill_r <= cnt_t'(DEPTH))
  `SSBM_ASSERT_NOW(a_drop_only_when_full, drop_r, fill_r == cnt_t'(DEPTH))
  `SSBM_ASSERT_NOW(a_merge_count_kept, cmd.merge, (k_r + mid) == (i_r + j_r))

endmodule

FILE: hdl/stable_sort_by_magnitude.sv
// Stable sort by ascending magnitude: top level joining ssbm_ctrl and ssbm_dp.
// Depends on ssbm_pkg, ssbm_ctrl, ssbm_dp and ssbm_ram.
//
// Usage:
//   Input channel (in_valid/in_ready, in_value, in_last) takes one signed value
//   per item; in_ready is high only while the block is collecting a set, one
//   item per cycle. The item with in_last = 1 closes the set. Up to DEPTH
//   values are stored; further items of the set are dropped and out_overflowed
//   is high on every result of that set.
//   After the last item, a bottom-up merge runs ceil(log2 n) passes between two
//   RAMs; each run pair first loads both heads (S_LDA, S_LDB), then each item
//   takes S_MERGE and S_FETCH, since one read port feeds the two merge heads.
//   Result channel (out_valid/out_ready, out_value, out_last, out_overflowed)
//   then gives the n values in order, out_last on the final one; each result
//   takes a RAM read, an output register load and a handshake before the next.
//   A stalled receiver holds the result register; nothing is lost.
//   Reset (rst_n low, synchronous) empties the set; the RAMs need no clearing,
//   so the block takes items right after reset.
module stable_sort_by_magnitude (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [ssbm_pkg::VALUE_WIDTH-1:0] in_value,
  input  logic                             in_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [ssbm_pkg::VALUE_WIDTH-1:0] out_value,
  output logic                             out_last,
  output logic                             out_overflowed
);

  import ssbm_pkg::*;

  ssbm_cmd_t cmd;
  ssbm_sts_t sts;
  val_t      out_value_u;

  ssbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssbm_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_value       (val_t'(in_value)),
    .out_value      (out_value_u),
    .out_last       (out_last),
    .out_overflowed (out_overflowed)
  );

  assign out_value = $signed(out_value_u);

endmodule
